// File: rtl/lkbs_pkg.sv
// Shared types and constants for the LCG keyed byte scrambler.
package lkbs_pkg;

   localparam int unsigned KEY_W       = 31;
   localparam int unsigned MASTER_W    = 24;
   localparam int unsigned ROT_W       = 3;
   localparam int unsigned KEY_INDEX_W = 8;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [KEY_W-1:0] LCG_MUL = 31'd1103515245;
   localparam logic [KEY_W-1:0] LCG_ADD = 31'd12345;
   localparam logic [7:0]       SUB_MUL = 8'd167;

   localparam logic [MASTER_W-1:0] MASTER_KEY_RESET    = 24'd65536;
   localparam logic [ROT_W-1:0]    ROTATE_AMOUNT_RESET = 3'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_KEY    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATE_AMOUNT = 1'b1;

   localparam logic FUNC_REBUILD = 1'b0;
   localparam logic FUNC_ENCRYPT = 1'b1;

   localparam logic KIND_REBUILD = 1'b0;
   localparam logic KIND_CIPHER  = 1'b1;

   typedef struct packed {
      logic                   func;
      logic [7:0]             data_byte;
      logic [KEY_INDEX_W-1:0] key_index;
      logic                   start_string;
      logic                   round_start;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] cipher_byte;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_REBUILD = 4'b0010,
      ST_FINISH  = 4'b0100,
      ST_CALC    = 4'b1000
   } state_type;

endpackage

// File: rtl/lkbs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lkbs_ram #(
   parameter int unsigned WIDTH = 31,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lkbs_byte_mix.sv
// Byte transform: key byte XOR, affine substitution, left rotation.
module lkbs_byte_mix import lkbs_pkg::*; (
   input  logic [7:0]          data_byte,
   input  logic [KEY_W-1:0]    running_key,
   input  logic [1:0]          pos_sel,
   input  logic [MASTER_W-1:0] master_key,
   input  logic [ROT_W-1:0]    rotate_amount,
   output logic [7:0]          cipher_byte
);

   logic [31:0] key_wide;
   logic [7:0]  key_byte;
   logic [7:0]  mixed;
   logic [7:0]  product;
   logic [7:0]  subst;
   logic [15:0] rot_pair;

   always_comb begin
      key_wide = {1'b0, running_key};
      key_byte = key_wide[{pos_sel, 3'b000} +: 8];
      mixed    = data_byte ^ key_byte;
      // only the low byte of the substitution survives
      product  = mixed * SUB_MUL;
      subst    = (product + master_key[7:0]) ^ master_key[15:8];
      rot_pair = {subst, subst} << rotate_amount;
   end

   assign cipher_byte = rot_pair[15:8];

endmodule

// File: rtl/lcg_keyed_byte_scrambler_core.sv
// Top level of the LCG keyed byte scrambler: sequencer, key table and result register.
//
//  Channel   Direction  Handshake              Word
//  req_      in         req_valid / req_stall  req_type
//  rsp_      out        rsp_valid / rsp_stall  rsp_type
//  csr_      in         csr_write_en           csr_index, csr_write_data
//
// Encrypt first accepts the word (key table read issued on start_string), then
// computes through the shared 31-bit multiplier. Rebuild walks all KEY_ENTRIES
// entries, one table write per cycle from the same multiplier, then the result.
// Reset is synchronous; the key table is not cleared and holds garbage until rebuilt.
// A stalled result register holds the sequencer in its final state; input
// words are taken only in idle.
module lcg_keyed_byte_scrambler_core import lkbs_pkg::*; #(
   parameter int unsigned KEY_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MASTER_W-1:0]    csr_write_data
);

   localparam int unsigned AW         = $clog2(KEY_ENTRIES);
   localparam int unsigned INDEX_VALS = 1 << KEY_INDEX_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [MASTER_W-1:0] master_key_ff;
   logic [ROT_W-1:0]    rotate_amount_ff;
   req_type             req_ff;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    pos_ff, pos_in;
   logic [KEY_W-1:0]    seed_ff, seed_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic              req_take;
   logic              out_free;
   logic [AW-1:0]     index_map [INDEX_VALS];
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [KEY_W-1:0]  mem_rd_data;
   logic [KEY_W-1:0]  key_src;
   logic [KEY_W-1:0]  pos_src;
   logic [KEY_W-1:0]  mul_a;
   logic [KEY_W-1:0]  mul_add;
   logic [KEY_W-1:0]  lcg_next;
   logic [7:0]        cipher_byte;

   // key_index modulo table size, folded at elaboration
   for (genvar g = 0; g < INDEX_VALS; g++) begin : g_index_map
      localparam int unsigned IDX = g % KEY_ENTRIES;
      assign index_map[g] = AW'(IDX);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign mem_rd_en = req_take && (req_data.func == FUNC_ENCRYPT) && req_data.start_string;
   assign mem_wr_en = (state_ff == ST_REBUILD);

   lkbs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KEY_ENTRIES)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (lcg_next),
      .rd_en   (mem_rd_en),
      .rd_addr (index_map[req_data.key_index]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      key_src = req_ff.start_string ? mem_rd_data : key_ff;
      pos_src = (req_ff.start_string || req_ff.round_start) ? '0 : pos_ff;
      // one multiplier serves table walk and key advance
      mul_a    = (state_ff == ST_REBUILD) ? seed_ff : key_src;
      mul_add  = (state_ff == ST_REBUILD) ? LCG_ADD : pos_src;
      lcg_next = mul_a * LCG_MUL + mul_add;
   end

   lkbs_byte_mix u_byte_mix (
      .data_byte     (req_ff.data_byte),
      .running_key   (key_src),
      .pos_sel       (pos_src[1:0]),
      .master_key    (master_key_ff),
      .rotate_amount (rotate_amount_ff),
      .cipher_byte   (cipher_byte)
   );

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      seed_in      = seed_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.func == FUNC_REBUILD) begin
                  seed_in  = KEY_W'(master_key_ff);
                  cnt_in   = '0;
                  state_in = ST_REBUILD;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_REBUILD: begin
            seed_in = lcg_next;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_in.item_kind   = KIND_REBUILD;
               out_in.cipher_byte = '0;
               out_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_CALC: begin
            // hold key and position until the result register frees up
            if (out_free) begin
               out_in.item_kind   = KIND_CIPHER;
               out_in.cipher_byte = cipher_byte;
               out_valid_in       = 1'b1;
               key_in             = lcg_next;
               pos_in             = pos_src + KEY_W'(1);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         key_ff           <= '0;
         pos_ff           <= '0;
         out_valid_ff     <= 1'b0;
         master_key_ff    <= MASTER_KEY_RESET;
         rotate_amount_ff <= ROTATE_AMOUNT_RESET;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_MASTER_KEY:    master_key_ff    <= csr_write_data;
               CSR_ROTATE_AMOUNT: rotate_amount_ff <= csr_write_data[ROT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      seed_ff <= seed_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input taken but sequencer did not leave idle");

   a_full_table_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && $past(state_ff) == ST_REBUILD) |-> $past(cnt_ff) == LAST_ADDR)
      else $error("table rebuild ended before the last entry");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_CALC || $past(state_ff) == ST_FINISH))
      else $error("result appeared outside a finishing state");

   a_encrypt_kind: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_CALC && state_ff == ST_IDLE) |-> (rsp_valid && rsp_data.item_kind == KIND_CIPHER))
      else $error("encrypt finished without a cipher word");

endmodule
